// File: rtl/core/stp_pkg.sv
// Shared constants, codes and types of the slot table round-robin picker.
package stp_pkg;

   // Table size and tag width.
   localparam int SLOTS    = 16;
   localparam int TAG_BITS = 16;

   // Derived widths.
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;
   // Slot counts up to 32 fit in six bits.
   localparam int CNT_W  = 6;

   // Operation codes.
   localparam logic [1:0] OP_SUBMIT   = 2'd0;
   localparam logic [1:0] OP_DONE_OK  = 2'd1;
   localparam logic [1:0] OP_DONE_ERR = 2'd2;
   localparam logic [1:0] OP_PICK     = 2'd3;

   // Result status codes.
   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_UNMANAGED  = 3'd1;
   localparam logic [2:0] STAT_REFUSED    = 3'd2;
   localparam logic [2:0] STAT_NONE_READY = 3'd3;
   localparam logic [2:0] STAT_STALE      = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MANAGED = 2'd0;
   localparam logic [1:0] CSR_STALE   = 2'd1;
   localparam logic [1:0] CSR_MIN_LAG = 2'd2;

   // Configuration reset values.
   localparam logic [4:0]  MANAGED_RST = 5'd16;
   localparam logic [31:0] STALE_RST   = 32'd2000000;
   localparam logic [31:0] MIN_LAG_RST = 32'd1000;

   // One entry of the occupant memory.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [31:0]      last_turn;
      logic [31:0]      inject_time;
   } mem_entry_type;

   // Outcome of the round-robin search.
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } find_result_type;

endpackage

// File: rtl/core/stp_rr_find.sv
// Round-robin search for the first eligible slot at or after a start index.
module stp_rr_find
   import stp_pkg::*;
(
   input  logic [SLOTS-1:0]  elig,
   input  logic [SLOT_W-1:0] start_idx,
   output find_result_type   result
);

   logic [SLOTS-1:0]  upper;
   logic              upper_any;
   logic [SLOT_W-1:0] upper_idx;
   logic [SLOT_W-1:0] low_idx;

   // Split the eligible set into the part at or after the start index.
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         upper[k] = elig[k] && (SLOT_W'(k) >= start_idx);
      end
   end

   // Lowest set bit of each set; scanning downward leaves the lowest one.
   always_comb begin
      upper_idx = '0;
      low_idx   = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (upper[k]) begin
            upper_idx = SLOT_W'(k);
         end
         if (elig[k]) begin
            low_idx = SLOT_W'(k);
         end
      end
   end

   // Wrap to the bottom of the table when nothing lies past the start.
   assign upper_any    = |upper;
   assign result.found = |elig;
   assign result.idx   = upper_any ? upper_idx : low_idx;

endmodule

// File: rtl/core/slot_table_round_robin_picker_top.sv
// Top level of the slot table round-robin picker: control, flags and occupant memory.
//
// The block keeps one request slot per managed core and handles one command at a time.
// A command is taken when start is high and busy is low. A submit or a completion
// presents its result after the occupant memory read and a step that decides and
// writes back; the strobe cycle can already take the next command. A pick presents
// its result after the cursor check, the round-robin search, and the memory read of
// the picked tag. When the slot count has been lowered to or below the stored cursor,
// the cursor is reduced by one subtraction of the count per cycle before the search.
// Every result is shown for exactly one cycle with rsp_valid high and cannot be held
// off, so take it then. Fields that do not apply to an operation read as zero. Write
// configuration only while busy is low and no result is outstanding.
module slot_table_round_robin_picker_top
   import stp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_slot_index,
   input  logic [15:0] req_target_tag,
   input  logic [31:0] req_target_last_turn,
   input  logic        req_target_blocked,
   input  logic [31:0] req_now_us,
   // Result channel.
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_evicted_valid,
   output logic [15:0] rsp_evicted_tag,
   output logic        rsp_picked_valid,
   output logic [4:0]  rsp_picked_slot,
   output logic [15:0] rsp_picked_tag,
   output logic        rsp_picked_failed,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MOD,
      ST_SCAN,
      ST_PTAG
   } state_type;

   // Configuration registers.
   logic [4:0]  managed_ff;
   logic [31:0] stale_ff;
   logic [31:0] min_lag_ff;

   // Control state and per-slot flags.
   state_type         state_ff;
   logic [SLOTS-1:0]  occ_ff;
   logic [SLOTS-1:0]  done_ff;
   logic [SLOTS-1:0]  failed_ff;
   logic [SLOT_W-1:0] cursor_ff;
   logic [SLOT_W-1:0] cur_ff;

   // Captured command.
   logic [1:0]       op_ff;
   logic [4:0]       slot_ff;
   logic [TAG_W-1:0] tag_ff;
   logic [31:0]      last_ff;
   logic [31:0]      now_ff;
   logic             blocked_ff;
   logic             lag_hit_ff;

   // Pick bookkeeping.
   logic [SLOT_W-1:0] pick_slot_ff;
   logic              pick_failed_ff;

   // Result registers.
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_evicted_valid_ff;
   logic [15:0] rsp_evicted_tag_ff;
   logic        rsp_picked_valid_ff;
   logic [4:0]  rsp_picked_slot_ff;
   logic [15:0] rsp_picked_tag_ff;
   logic        rsp_picked_failed_ff;

   // Occupant memory.
   mem_entry_type     mem [SLOTS];
   mem_entry_type     rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              mem_we;

   // Decision signals.
   logic [CNT_W-1:0]  n_eff;
   logic [SLOT_W-1:0] sidx;
   logic              unmanaged;
   logic              slot_occ;
   logic              slot_done;
   logic              stale_hold;
   logic              submit_refuse;
   logic              complete_match;
   logic              lag_hit_in;
   logic [SLOTS-1:0]  elig;
   find_result_type   find;
   logic [CNT_W-1:0]  next_cursor;
   logic [SLOT_W-1:0] cursor_in;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         managed_ff <= MANAGED_RST;
         stale_ff   <= STALE_RST;
         min_lag_ff <= MIN_LAG_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MANAGED: managed_ff <= csr_wdata[4:0];
            CSR_STALE:   stale_ff   <= csr_wdata;
            CSR_MIN_LAG: min_lag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective slot count, clipped to the table size.
   assign n_eff = ({1'b0, managed_ff} >= CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : {1'b0, managed_ff};

   // Minimum lag check on the incoming command, formed without wrap.
   assign lag_hit_in = {1'b0, req_now_us} < ({1'b0, req_target_last_turn} + {1'b0, min_lag_ff});

   // Submit and completion decisions from the captured command and the memory read.
   assign sidx           = slot_ff[SLOT_W-1:0];
   assign unmanaged      = {1'b0, slot_ff} >= n_eff;
   assign slot_occ       = occ_ff[sidx];
   assign slot_done      = done_ff[sidx];
   assign stale_hold     = (last_ff >= rd_data_ff.last_turn) &&
                           ({1'b0, now_ff} < ({1'b0, rd_data_ff.inject_time} + {1'b0, stale_ff}));
   assign submit_refuse  = blocked_ff || lag_hit_ff || (slot_occ && (slot_done || stale_hold));
   assign complete_match = slot_occ && !slot_done && (rd_data_ff.tag == tag_ff);

   // Completed occupants within the managed range are candidates for a pick.
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         elig[k] = occ_ff[k] && done_ff[k] && (CNT_W'(k) < n_eff);
      end
   end

   stp_rr_find u_find (
      .elig      (elig),
      .start_idx (cur_ff),
      .result    (find)
   );

   // Cursor moves past the picked slot and wraps at the slot count.
   assign next_cursor = CNT_W'(find.idx) + CNT_W'(1);
   assign cursor_in   = (next_cursor == n_eff) ? '0 : SLOT_W'(next_cursor);

   // Memory address: the command's slot on transfer, the found slot during the search.
   assign rd_addr = (state_ff == ST_SCAN) ? find.idx : req_slot_index[SLOT_W-1:0];
   assign mem_we  = (state_ff == ST_EVAL) && !unmanaged && (op_ff == OP_SUBMIT) &&
                    !submit_refuse;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[sidx] <= '{tag: tag_ff, last_turn: last_ff, inject_time: now_ff};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control sequencer, slot flags and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         done_ff      <= '0;
         failed_ff    <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff      <= req_opcode;
                  slot_ff    <= req_slot_index;
                  tag_ff     <= req_target_tag[TAG_W-1:0];
                  last_ff    <= req_target_last_turn;
                  now_ff     <= req_now_us;
                  blocked_ff <= req_target_blocked;
                  lag_hit_ff <= lag_hit_in;
                  cur_ff     <= cursor_ff;
                  state_ff   <= (req_opcode == OP_PICK) ? ST_MOD : ST_EVAL;
               end
            end

            ST_EVAL: begin
               rsp_valid_ff         <= 1'b1;
               rsp_evicted_valid_ff <= 1'b0;
               rsp_evicted_tag_ff   <= '0;
               rsp_picked_valid_ff  <= 1'b0;
               rsp_picked_slot_ff   <= '0;
               rsp_picked_tag_ff    <= '0;
               rsp_picked_failed_ff <= 1'b0;
               state_ff             <= ST_IDLE;
               if (unmanaged) begin
                  rsp_status_ff <= STAT_UNMANAGED;
               end else if (op_ff == OP_SUBMIT) begin
                  if (submit_refuse) begin
                     rsp_status_ff <= STAT_REFUSED;
                  end else begin
                     rsp_status_ff        <= STAT_OK;
                     rsp_evicted_valid_ff <= slot_occ;
                     rsp_evicted_tag_ff   <= slot_occ ? 16'(rd_data_ff.tag) : '0;
                     occ_ff[sidx]         <= 1'b1;
                     done_ff[sidx]        <= 1'b0;
                     failed_ff[sidx]      <= 1'b0;
                  end
               end else if (complete_match) begin
                  rsp_status_ff   <= STAT_OK;
                  done_ff[sidx]   <= 1'b1;
                  failed_ff[sidx] <= (op_ff == OP_DONE_ERR);
               end else begin
                  rsp_status_ff <= STAT_STALE;
               end
            end

            ST_MOD: begin
               // None ready if no slots; else bring a left-over cursor into range.
               if (n_eff == '0) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_status_ff        <= STAT_NONE_READY;
                  rsp_evicted_valid_ff <= 1'b0;
                  rsp_evicted_tag_ff   <= '0;
                  rsp_picked_valid_ff  <= 1'b0;
                  rsp_picked_slot_ff   <= '0;
                  rsp_picked_tag_ff    <= '0;
                  rsp_picked_failed_ff <= 1'b0;
                  state_ff             <= ST_IDLE;
               end else if ({1'b0, cur_ff} >= n_eff) begin
                  cur_ff <= SLOT_W'({1'b0, cur_ff} - n_eff);
               end else begin
                  state_ff <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               if (!find.found) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_status_ff        <= STAT_NONE_READY;
                  rsp_evicted_valid_ff <= 1'b0;
                  rsp_evicted_tag_ff   <= '0;
                  rsp_picked_valid_ff  <= 1'b0;
                  rsp_picked_slot_ff   <= '0;
                  rsp_picked_tag_ff    <= '0;
                  rsp_picked_failed_ff <= 1'b0;
                  state_ff             <= ST_IDLE;
               end else begin
                  pick_slot_ff        <= find.idx;
                  pick_failed_ff      <= failed_ff[find.idx];
                  occ_ff[find.idx]    <= 1'b0;
                  done_ff[find.idx]   <= 1'b0;
                  failed_ff[find.idx] <= 1'b0;
                  cursor_ff           <= cursor_in;
                  state_ff            <= ST_PTAG;
               end
            end

            ST_PTAG: begin
               // The picked tag arrives from the memory in this cycle.
               rsp_valid_ff         <= 1'b1;
               rsp_status_ff        <= STAT_OK;
               rsp_evicted_valid_ff <= 1'b0;
               rsp_evicted_tag_ff   <= '0;
               rsp_picked_valid_ff  <= 1'b1;
               rsp_picked_slot_ff   <= 5'(pick_slot_ff);
               rsp_picked_tag_ff    <= 16'(rd_data_ff.tag);
               rsp_picked_failed_ff <= pick_failed_ff;
               state_ff             <= ST_IDLE;
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Port drive.
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_tag   = rsp_evicted_tag_ff;
   assign rsp_picked_valid  = rsp_picked_valid_ff;
   assign rsp_picked_slot   = rsp_picked_slot_ff;
   assign rsp_picked_tag    = rsp_picked_tag_ff;
   assign rsp_picked_failed = rsp_picked_failed_ff;

endmodule

// File: rtl/core/stp_checker.sv
// Port-level assertions for the slot table round-robin picker, bound to the top level.
module stp_checker
   import stp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic        rsp_evicted_valid,
   input logic        rsp_picked_valid,
   input logic [15:0] rsp_picked_tag
);

   // A command transfer makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not raise busy");

   // Results never come in consecutive cycles, since each command passes through a working state before its result.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in consecutive cycles");

   // A result is shown only once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A successful pick reports ok status and no eviction.
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_picked_valid) |-> (rsp_status == STAT_OK && !rsp_evicted_valid))
      else $error("picked result with wrong status or eviction");

   // An empty pick carries no picked occupant.
   a_none_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_NONE_READY) |-> (!rsp_picked_valid && rsp_picked_tag == '0))
      else $error("empty pick carries a picked occupant");

endmodule

bind slot_table_round_robin_picker_top stp_checker u_stp_checker (.*);
